/* rtl/aar_pkg.sv */
// Shared constants, types and tables for the axis-angle rotation matrix generator.
package aar_pkg;

	localparam int FRAC_BITS_DEF    = 14;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int IN_W             = 16;
	localparam int OUT_W            = 16;
	localparam int ANG_W            = 34;
	localparam int ANG_SHIFT        = 17;
	localparam int N2_W             = 32;
	localparam int RAD_PAD          = 30;
	localparam int RAD_W            = N2_W + RAD_PAD;
	localparam int ROOT_W           = 31;
	localparam int REM_W            = 32;
	localparam int ATAN_W           = 30;
	localparam int FIFO_DEPTH       = 4;

	localparam logic signed [ANG_W-1:0] ANG_PI      = 34'sd3373259426;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd1686629713;
	localparam longint                  CORDIC_GAIN = 64'sd652032874;
	localparam logic signed [OUT_W-1:0] OUT_ONE     = 16'sd16384;

	// Sideband that travels with the axis through the square root and divider.
	typedef struct packed {
		logic signed [ANG_W-1:0] h;
		logic                    flip;
		logic                    invalid;
		logic [2:0]              neg;
		logic [2:0][IN_W-1:0]    mag;
	} aar_side_t;

	// atan(2^-i) scaled by 2^30, truncated.
	function automatic logic [ATAN_W-1:0] atan_val(input int i);
		case (i)
			0:  atan_val = 30'h3243F6A8;
			1:  atan_val = 30'h1DAC6705;
			2:  atan_val = 30'h0FADBAFC;
			3:  atan_val = 30'h07F56EA6;
			4:  atan_val = 30'h03FEAB76;
			5:  atan_val = 30'h01FFD55B;
			6:  atan_val = 30'h00FFFAAA;
			7:  atan_val = 30'h007FFF55;
			8:  atan_val = 30'h003FFFEA;
			9:  atan_val = 30'h001FFFFD;
			10: atan_val = 30'h000FFFFF;
			11: atan_val = 30'h0007FFFF;
			12: atan_val = 30'h0003FFFF;
			13: atan_val = 30'h0001FFFF;
			14: atan_val = 30'h0000FFFF;
			15: atan_val = 30'h00007FFF;
			16: atan_val = 30'h00003FFF;
			17: atan_val = 30'h00001FFF;
			18: atan_val = 30'h00000FFF;
			19: atan_val = 30'h000007FF;
			20: atan_val = 30'h000003FF;
			21: atan_val = 30'h000001FF;
			22: atan_val = 30'h000000FF;
			23: atan_val = 30'h0000007F;
			24: atan_val = 30'h0000003F;
			25: atan_val = 30'h0000001F;
			26: atan_val = 30'h0000000F;
			27: atan_val = 30'h00000007;
			28: atan_val = 30'h00000003;
			29: atan_val = 30'h00000001;
			default: atan_val = '0;
		endcase
	endfunction

	// CORDIC start value: the gain rounded from Q.30 to Q.f.
	function automatic longint gain_init(input int f);
		if (f >= 30)
			return CORDIC_GAIN;
		return (CORDIC_GAIN + (64'sd1 <<< (29 - f))) >>> (30 - f);
	endfunction

endpackage

/* rtl/axis_angle_rotation_matrix.sv */
// Top level of the axis-angle to rotation matrix generator.
//
// Usage: drive angle (Q3.12 radians) and axis_x/y/z (Q1.14, any length) and raise start.
// A transaction is taken at each rising edge where start is high and busy is low; a new
// transaction may be offered every cycle, so one matrix per clock is sustained.
// Each transaction yields exactly one result: done is high for exactly one cycle and
// m00..m22 (Q1.14, saturated to +-1.0) and axis_invalid are valid in that cycle only.
// The result path runs through the square root (one root bit per stage, 31 stages), the
// divider (FRAC_BITS + 1 stages, one quotient bit each), the queue and the CORDIC (one
// stage per step), followed by the quaternion and matrix multiplier stages.
// Results come out in the order the transactions were taken.
// A zero axis sets axis_invalid and returns the identity matrix.
// The receiver cannot stall: results are presented once and never held. The queue between
// the front end and the back end drains every cycle, so busy stays low in operation.
// Reset (arst_n low) clears every valid flag at once; no transaction survives reset and
// nothing is needed before the first start.
module axis_angle_rotation_matrix import aar_pkg::*; #(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [IN_W-1:0]  angle,
	input  logic signed [IN_W-1:0]  axis_x,
	input  logic signed [IN_W-1:0]  axis_y,
	input  logic signed [IN_W-1:0]  axis_z,
	output logic                    done,
	output logic signed [OUT_W-1:0] m00,
	output logic signed [OUT_W-1:0] m01,
	output logic signed [OUT_W-1:0] m02,
	output logic signed [OUT_W-1:0] m10,
	output logic signed [OUT_W-1:0] m11,
	output logic signed [OUT_W-1:0] m12,
	output logic signed [OUT_W-1:0] m20,
	output logic signed [OUT_W-1:0] m21,
	output logic signed [OUT_W-1:0] m22,
	output logic                    axis_invalid
);

	localparam int UW = FRAC_BITS + 2;
	localparam int QW = 3 * UW + ANG_W + 2;

	logic                    accept;
	logic                    f_valid;
	logic signed [UW-1:0]    f_ux, f_uy, f_uz;
	logic signed [ANG_W-1:0] f_h;
	logic                    f_flip, f_inv;
	logic                    q_full, q_valid;
	logic [QW-1:0]           q_wdata, q_rdata;
	logic signed [UW-1:0]    b_ux, b_uy, b_uz;
	logic signed [ANG_W-1:0] b_h;
	logic                    b_flip, b_inv;
	logic signed [OUT_W-1:0] m [9];

	assign busy   = q_full;
	assign accept = start && !busy;

	aar_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.angle     (angle),
		.axis_x    (axis_x),
		.axis_y    (axis_y),
		.axis_z    (axis_z),
		.out_valid (f_valid),
		.ux        (f_ux),
		.uy        (f_uy),
		.uz        (f_uz),
		.h         (f_h),
		.flip      (f_flip),
		.invalid   (f_inv)
	);

	// The queue word carries the unit axis and the folded half angle.
	assign q_wdata = {f_ux, f_uy, f_uz, f_h, f_flip, f_inv};

	aar_fifo #(
		.W     (QW),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid),
		.wdata     (q_wdata),
		.full      (q_full),
		.out_valid (q_valid),
		.rdata     (q_rdata)
	);

	assign {b_ux, b_uy, b_uz, b_h, b_flip, b_inv} = q_rdata;

	aar_back #(
		.FRAC_BITS    (FRAC_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (q_valid),
		.ux           (b_ux),
		.uy           (b_uy),
		.uz           (b_uz),
		.h            (b_h),
		.flip         (b_flip),
		.invalid      (b_inv),
		.done         (done),
		.m            (m),
		.axis_invalid (axis_invalid)
	);

	assign m00 = m[0];
	assign m01 = m[1];
	assign m02 = m[2];
	assign m10 = m[3];
	assign m11 = m[4];
	assign m12 = m[5];
	assign m20 = m[6];
	assign m21 = m[7];
	assign m22 = m[8];

endmodule

/* rtl/aar_front.sv */
// Front end: axis length by pipelined square root, unit axis by pipelined division, angle folding.
module aar_front import aar_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic signed [IN_W-1:0]   angle,
	input  logic signed [IN_W-1:0]   axis_x,
	input  logic signed [IN_W-1:0]   axis_y,
	input  logic signed [IN_W-1:0]   axis_z,
	output logic                     out_valid,
	output logic signed [FRAC_BITS+1:0] ux,
	output logic signed [FRAC_BITS+1:0] uy,
	output logic signed [FRAC_BITS+1:0] uz,
	output logic signed [ANG_W-1:0]  h,
	output logic                     flip,
	output logic                     invalid
);

	localparam int QB = FRAC_BITS + 1;
	localparam int NW = FRAC_BITS + 32;
	localparam int SQ_W = 2 * IN_W - 1;

	logic                  valid_s1;
	logic signed [IN_W-1:0] angle_s1;
	logic signed [IN_W-1:0] axis_s1 [3];

	logic                  valid_s2;
	logic signed [IN_W-1:0] angle_s2;
	logic [SQ_W-1:0]       sq_s2 [3];
	logic [2:0]            neg_s2;
	logic [2:0][IN_W-1:0]  mag_s2;

	logic                  rt_valid_s [0:ROOT_W];
	logic [REM_W-1:0]      rt_rem_s   [0:ROOT_W];
	logic [ROOT_W-1:0]     rt_root_s  [0:ROOT_W];
	logic [RAD_W-1:0]      rt_rad_s   [0:ROOT_W];
	aar_side_t             rt_side_s  [0:ROOT_W];

	logic                  dv_valid_s [0:QB];
	logic [ROOT_W-1:0]     dv_len_s   [0:QB];
	logic [ROOT_W-1:0]     dv_rem_s   [0:QB][3];
	logic [QB-1:0]         dv_low_s   [0:QB][3];
	logic [QB-1:0]         dv_quo_s   [0:QB][3];
	aar_side_t             dv_side_s  [0:QB];

	logic [N2_W-1:0]        n2;
	logic signed [ANG_W-1:0] h_raw;
	aar_side_t              side_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			rt_valid_s[0] <= 1'b0;
		end else begin
			valid_s1      <= in_valid;
			valid_s2      <= valid_s1;
			rt_valid_s[0] <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		angle_s1   <= angle;
		axis_s1[0] <= axis_x;
		axis_s1[1] <= axis_y;
		axis_s1[2] <= axis_z;
		angle_s2   <= angle_s1;
		for (int c = 0; c < 3; c++) begin
			sq_s2[c]  <= SQ_W'(axis_s1[c] * axis_s1[c]);
			neg_s2[c] <= axis_s1[c][IN_W-1];
			mag_s2[c] <= axis_s1[c][IN_W-1] ? IN_W'(-axis_s1[c]) : IN_W'(axis_s1[c]);
		end
	end

	// Squared length, zero-axis detection and folding of the half angle into +-pi/2.
	always_comb begin
		n2    = N2_W'(sq_s2[0]) + N2_W'(sq_s2[1]) + N2_W'(sq_s2[2]);
		h_raw = ANG_W'(angle_s2) <<< ANG_SHIFT;
		side_in.invalid = (n2 == '0);
		side_in.neg     = neg_s2;
		side_in.mag     = mag_s2;
		side_in.flip    = 1'b0;
		side_in.h       = h_raw;
		if (h_raw > ANG_HALF_PI) begin
			side_in.h    = h_raw - ANG_PI;
			side_in.flip = 1'b1;
		end else if (h_raw < -ANG_HALF_PI) begin
			side_in.h    = h_raw + ANG_PI;
			side_in.flip = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rt_rem_s[0]  <= '0;
		rt_root_s[0] <= '0;
		rt_rad_s[0]  <= {n2, {RAD_PAD{1'b0}}};
		rt_side_s[0] <= side_in;
	end

	// One root bit per stage, restoring method on the remainder.
	for (genvar j = 0; j < ROOT_W; j++) begin : g_root
		logic [REM_W+1:0] cur;
		logic [REM_W+1:0] trial;
		logic             ge;
		assign cur   = {rt_rem_s[j], rt_rad_s[j][RAD_W-1 -: 2]};
		assign trial = {1'b0, rt_root_s[j], 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				rt_valid_s[j+1] <= 1'b0;
			else
				rt_valid_s[j+1] <= rt_valid_s[j];
		end

		always_ff @(posedge clk) begin
			rt_rem_s[j+1]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
			rt_root_s[j+1] <= {rt_root_s[j][ROOT_W-2:0], ge};
			rt_rad_s[j+1]  <= {rt_rad_s[j][RAD_W-3:0], 2'b00};
			rt_side_s[j+1] <= rt_side_s[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_valid_s[0] <= 1'b0;
		else
			dv_valid_s[0] <= rt_valid_s[ROOT_W];
	end

	// Divider setup: numerator is the magnitude scaled up plus half the length for rounding.
	always_ff @(posedge clk) begin
		logic [NW-1:0] num;
		dv_len_s[0]  <= rt_root_s[ROOT_W];
		dv_side_s[0] <= rt_side_s[ROOT_W];
		for (int c = 0; c < 3; c++) begin
			num = (NW'(rt_side_s[ROOT_W].mag[c]) << (FRAC_BITS + 15))
				+ NW'(rt_root_s[ROOT_W] >> 1);
			dv_rem_s[0][c] <= num[NW-1:QB];
			dv_low_s[0][c] <= num[QB-1:0];
			dv_quo_s[0][c] <= '0;
		end
	end

	// One quotient bit per stage for all three components.
	for (genvar k = 0; k < QB; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_valid_s[k+1] <= 1'b0;
			else
				dv_valid_s[k+1] <= dv_valid_s[k];
		end

		always_ff @(posedge clk) begin
			logic [ROOT_W:0] cur;
			logic            ge;
			dv_len_s[k+1]  <= dv_len_s[k];
			dv_side_s[k+1] <= dv_side_s[k];
			for (int c = 0; c < 3; c++) begin
				cur = {dv_rem_s[k][c], dv_low_s[k][c][QB-1]};
				ge  = (cur >= {1'b0, dv_len_s[k]});
				dv_rem_s[k+1][c] <= ge ? ROOT_W'(cur - {1'b0, dv_len_s[k]}) : cur[ROOT_W-1:0];
				dv_low_s[k+1][c] <= {dv_low_s[k][c][QB-2:0], 1'b0};
				dv_quo_s[k+1][c] <= {dv_quo_s[k][c][QB-2:0], ge};
			end
		end
	end

	assign out_valid = dv_valid_s[QB];
	assign h         = dv_side_s[QB].h;
	assign flip      = dv_side_s[QB].flip;
	assign invalid   = dv_side_s[QB].invalid;
	assign ux = dv_side_s[QB].neg[0] ? -signed'({1'b0, dv_quo_s[QB][0]})
		: signed'({1'b0, dv_quo_s[QB][0]});
	assign uy = dv_side_s[QB].neg[1] ? -signed'({1'b0, dv_quo_s[QB][1]})
		: signed'({1'b0, dv_quo_s[QB][1]});
	assign uz = dv_side_s[QB].neg[2] ? -signed'({1'b0, dv_quo_s[QB][2]})
		: signed'({1'b0, dv_quo_s[QB][2]});

endmodule

/* rtl/aar_fifo.sv */
// Short queue between the front end and the back end, with registered read data.
module aar_fifo import aar_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	output logic         out_valid,
	output logic [W-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          out_valid_q;
	logic [W-1:0]  rdata_q;
	logic          pop;

	// The back end never stalls, so an entry leaves as soon as there is one.
	assign pop  = (count_q != '0);
	assign full = (count_q == CW'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			count_q     <= count_q + CW'(push) - CW'(pop);
			out_valid_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (pop)
			rdata_q <= mem[rd_ptr_q];
	end

	assign out_valid = out_valid_q;
	assign rdata     = rdata_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue written while full");
	a_drained: assert property (@(posedge clk) disable iff (!arst_n) count_q < CW'(2))
		else $error("queue holds more than one entry");
	a_read_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $past(count_q != '0))
		else $error("read data marked valid without an entry");

endmodule

/* rtl/aar_back.sv */
// Back end: pipelined CORDIC for the half angle, quaternion and matrix entries.
module aar_back import aar_pkg::*; #(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic signed [FRAC_BITS+1:0] ux,
	input  logic signed [FRAC_BITS+1:0] uy,
	input  logic signed [FRAC_BITS+1:0] uz,
	input  logic signed [ANG_W-1:0]     h,
	input  logic                        flip,
	input  logic                        invalid,
	output logic                        done,
	output logic signed [OUT_W-1:0]     m [9],
	output logic                        axis_invalid
);

	localparam int N   = CORDIC_STEPS;
	localparam int UW  = FRAC_BITS + 2;
	localparam int XW  = FRAC_BITS + 3;
	localparam int P1W = XW + UW;
	localparam int QW  = FRAC_BITS + 3;
	localparam int PW  = 2 * QW;
	localparam int EW  = PW + 3;
	localparam int SH  = 2 * FRAC_BITS - 14;
	localparam logic signed [P1W-1:0] Q_RND  = P1W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [EW-1:0]  E_RND  = EW'(1) <<< (SH - 1);
	localparam logic signed [EW-1:0]  E_ONE  = EW'(1) <<< (2 * FRAC_BITS);
	localparam logic signed [EW-1:0]  SAT_HI = EW'(OUT_ONE);
	localparam logic signed [EW-1:0]  SAT_LO = -SAT_HI;

	logic                    c_valid_s [0:N];
	logic signed [XW-1:0]    cx_s      [0:N];
	logic signed [XW-1:0]    cy_s      [0:N];
	logic signed [ANG_W-1:0] ch_s      [0:N];
	logic signed [UW-1:0]    cu_s      [0:N][3];
	logic                    cflip_s   [0:N];
	logic                    cinv_s    [0:N];

	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic                 inv_s1, inv_s2, inv_s3, inv_s4;
	logic signed [XW-1:0] x_s1, y_s1, a_s2;
	logic signed [UW-1:0] u_s1 [3];
	logic signed [P1W-1:0] p_s2 [3];
	logic signed [QW-1:0] a_s3, b_s3, c_s3, d_s3;
	logic signed [PW-1:0] bb_s4, cc_s4, dd_s4, bc_s4, bd_s4, cd_s4, ab_s4, ac_s4, ad_s4;
	logic                 done_q;
	logic                 inv_q;
	logic signed [OUT_W-1:0] m_q [9];

	function automatic logic signed [OUT_W-1:0] to_out(input logic signed [EW-1:0] v);
		logic signed [EW-1:0] r;
		r = (v + E_RND) >>> SH;
		if (r > SAT_HI)
			r = SAT_HI;
		if (r < SAT_LO)
			r = SAT_LO;
		return OUT_W'(r);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			c_valid_s[0] <= 1'b0;
		else
			c_valid_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		cx_s[0]    <= XW'(gain_init(FRAC_BITS));
		cy_s[0]    <= '0;
		ch_s[0]    <= h;
		cu_s[0][0] <= ux;
		cu_s[0][1] <= uy;
		cu_s[0][2] <= uz;
		cflip_s[0] <= flip;
		cinv_s[0]  <= invalid;
	end

	// One micro-rotation per stage, direction from the sign of the residual angle.
	for (genvar i = 0; i < N; i++) begin : g_cordic
		localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(atan_val(i));
		logic signed [XW-1:0] dx, dy;
		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				c_valid_s[i+1] <= 1'b0;
			else
				c_valid_s[i+1] <= c_valid_s[i];
		end

		always_ff @(posedge clk) begin
			if (!ch_s[i][ANG_W-1]) begin
				cx_s[i+1] <= cx_s[i] - dx;
				cy_s[i+1] <= cy_s[i] + dy;
				ch_s[i+1] <= ch_s[i] - ATAN;
			end else begin
				cx_s[i+1] <= cx_s[i] + dx;
				cy_s[i+1] <= cy_s[i] - dy;
				ch_s[i+1] <= ch_s[i] + ATAN;
			end
			cu_s[i+1]    <= cu_s[i];
			cflip_s[i+1] <= cflip_s[i];
			cinv_s[i+1]  <= cinv_s[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= c_valid_s[N];
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			done_q   <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		// Undo the pi fold of the half angle.
		x_s1   <= cflip_s[N] ? -cx_s[N] : cx_s[N];
		y_s1   <= cflip_s[N] ? -cy_s[N] : cy_s[N];
		u_s1   <= cu_s[N];
		inv_s1 <= cinv_s[N];

		for (int c = 0; c < 3; c++)
			p_s2[c] <= P1W'(y_s1) * P1W'(u_s1[c]);
		a_s2   <= x_s1;
		inv_s2 <= inv_s1;

		a_s3   <= QW'(a_s2);
		b_s3   <= QW'((p_s2[0] + Q_RND) >>> FRAC_BITS);
		c_s3   <= QW'((p_s2[1] + Q_RND) >>> FRAC_BITS);
		d_s3   <= QW'((p_s2[2] + Q_RND) >>> FRAC_BITS);
		inv_s3 <= inv_s2;

		bb_s4  <= PW'(b_s3) * PW'(b_s3);
		cc_s4  <= PW'(c_s3) * PW'(c_s3);
		dd_s4  <= PW'(d_s3) * PW'(d_s3);
		bc_s4  <= PW'(b_s3) * PW'(c_s3);
		bd_s4  <= PW'(b_s3) * PW'(d_s3);
		cd_s4  <= PW'(c_s3) * PW'(d_s3);
		ab_s4  <= PW'(a_s3) * PW'(b_s3);
		ac_s4  <= PW'(a_s3) * PW'(c_s3);
		ad_s4  <= PW'(a_s3) * PW'(d_s3);
		inv_s4 <= inv_s3;

		inv_q <= inv_s4;
		if (inv_s4) begin
			for (int e = 0; e < 9; e++)
				m_q[e] <= (e % 4 == 0) ? OUT_ONE : '0;
		end else begin
			m_q[0] <= to_out(E_ONE - ((EW'(cc_s4) + EW'(dd_s4)) <<< 1));
			m_q[1] <= to_out((EW'(bc_s4) - EW'(ad_s4)) <<< 1);
			m_q[2] <= to_out((EW'(bd_s4) + EW'(ac_s4)) <<< 1);
			m_q[3] <= to_out((EW'(bc_s4) + EW'(ad_s4)) <<< 1);
			m_q[4] <= to_out(E_ONE - ((EW'(bb_s4) + EW'(dd_s4)) <<< 1));
			m_q[5] <= to_out((EW'(cd_s4) - EW'(ab_s4)) <<< 1);
			m_q[6] <= to_out((EW'(bd_s4) - EW'(ac_s4)) <<< 1);
			m_q[7] <= to_out((EW'(cd_s4) + EW'(ab_s4)) <<< 1);
			m_q[8] <= to_out(E_ONE - ((EW'(bb_s4) + EW'(cc_s4)) <<< 1));
		end
	end

	assign done         = done_q;
	assign m            = m_q;
	assign axis_invalid = inv_q;

endmodule

/* tb/axis_angle_rotation_matrix_tb.sv */
// Self-checking testbench for the axis-angle to rotation matrix generator.
`timescale 1ns / 1ps

// Each transaction is predicted in the same fixed-point steps at the moment it is accepted, and the
// expected matrix waits in a queue. A monitor compares every done strobe, entry by entry,
// with the oldest prediction. Stimulus runs in phases with different amounts of sender idling.
module axis_angle_rotation_matrix_tb;
	import aar_pkg::*;

	localparam int FB    = FRAC_BITS_DEF;
	localparam int STEPS = CORDIC_STEPS_DEF;
	// Edges from acceptance until the result is taken; the drain wait uses some margin.
	localparam int LATENCY = FB + STEPS + 44;

	typedef struct {
		logic signed [OUT_W-1:0] m [9];
		logic                    invalid;
	} matrix_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic signed [IN_W-1:0]  angle, axis_x, axis_y, axis_z;
	logic                    done;
	logic signed [OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic                    axis_invalid;

	matrix_t expected_matrices [$];
	int      idle_pct;
	int      n_sent;
	int      n_checked;
	int      n_invalid_axes;
	int      n_errors;

	axis_angle_rotation_matrix u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.angle(angle), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.done(done),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22), .axis_invalid(axis_invalid)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The whole run fits well inside this bound, even with every idle phase at its worst.
	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// floor division by a power of two, for any sign.
	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	// Round to nearest, halves toward +infinity.
	function automatic longint round_shift(longint v, int s);
		if (s == 0)
			return v;
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Axis component scaled to unit length in Q.FB, rounded half up on the magnitude.
	function automatic longint unit_part(longint v, longint unsigned len);
		longint unsigned mag, q;
		mag = (v < 0) ? -v : v;
		q = ((mag << (FB + 15)) + len / 2) / len;
		return (v < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [OUT_W-1:0] to_q14(longint v);
		longint r;
		r = round_shift(v, 2 * FB - 14);
		if (r > 16384)
			r = 16384;
		if (r < -16384)
			r = -16384;
		return r[OUT_W-1:0];
	endfunction

	// Full prediction of one rotation matrix from angle and axis.
	function automatic matrix_t rotation_of(logic signed [IN_W-1:0] ang,
			logic signed [IN_W-1:0] ax, logic signed [IN_W-1:0] ay,
			logic signed [IN_W-1:0] az);
		matrix_t r;
		longint vx, vy, vz, n2, ux, uy, uz, h, x, y, dx, dy, qa, qb, qc, qd, one;
		longint unsigned len;
		logic flip;
		vx = ax;
		vy = ay;
		vz = az;
		n2 = vx * vx + vy * vy + vz * vz;
		if (n2 == 0) begin
			foreach (r.m[i])
				r.m[i] = (i % 4 == 0) ? OUT_ONE : '0;
			r.invalid = 1'b1;
			return r;
		end
		len = int_sqrt(longint'(n2) << 30);
		ux = unit_part(vx, len);
		uy = unit_part(vy, len);
		uz = unit_part(vz, len);
		// Half angle in Q.30, folded into +-pi/2 with a sign flip of cos and sin.
		h = longint'(ang) * 131072;
		flip = 1'b0;
		if (h > longint'(ANG_HALF_PI)) begin
			h -= longint'(ANG_PI);
			flip = 1'b1;
		end else if (h < -longint'(ANG_HALF_PI)) begin
			h += longint'(ANG_PI);
			flip = 1'b1;
		end
		x = round_shift(CORDIC_GAIN, 30 - FB);
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (h >= 0) begin
				x -= dx;
				y += dy;
				h -= longint'(atan_val(i));
			end else begin
				x += dx;
				y -= dy;
				h += longint'(atan_val(i));
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		qa = x;
		qb = round_shift(y * ux, FB);
		qc = round_shift(y * uy, FB);
		qd = round_shift(y * uz, FB);
		one = 64'sd1 <<< (2 * FB);
		r.m[0] = to_q14(one - 2 * (qc * qc + qd * qd));
		r.m[1] = to_q14(2 * (qb * qc - qd * qa));
		r.m[2] = to_q14(2 * (qb * qd + qc * qa));
		r.m[3] = to_q14(2 * (qb * qc + qd * qa));
		r.m[4] = to_q14(one - 2 * (qb * qb + qd * qd));
		r.m[5] = to_q14(2 * (qc * qd - qb * qa));
		r.m[6] = to_q14(2 * (qb * qd - qc * qa));
		r.m[7] = to_q14(2 * (qc * qd + qb * qa));
		r.m[8] = to_q14(one - 2 * (qb * qb + qc * qc));
		r.invalid = 1'b0;
		return r;
	endfunction

	// Offers one transaction and holds it until accepted. Start stays high when the next
	// call follows directly and draws no idling, so back-to-back transactions never see a low blip.
	task automatic send_rotation(logic signed [IN_W-1:0] ang, logic signed [IN_W-1:0] ax,
			logic signed [IN_W-1:0] ay, logic signed [IN_W-1:0] az);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start  <= 1'b1;
		angle  <= ang;
		axis_x <= ax;
		axis_y <= ay;
		axis_z <= az;
		do
			@(posedge clk);
		while (busy);
		expected_matrices.push_back(rotation_of(ang, ax, ay, az));
		n_sent++;
		if (ax == 0 && ay == 0 && az == 0)
			n_invalid_axes++;
		@(negedge clk);
	endtask

	task automatic go_quiet();
		start <= 1'b0;
	endtask

	// Result monitor: every done strobe must match the oldest prediction.
	always @(posedge clk) begin
		matrix_t want;
		logic signed [OUT_W-1:0] got [9];
		if (arst_n && done) begin
			got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
			if (expected_matrices.size() == 0) begin
				$error("result with no transaction outstanding");
				n_errors++;
			end else begin
				want = expected_matrices.pop_front();
				n_checked++;
				foreach (got[i])
					if (got[i] !== want.m[i]) begin
						$error("m%0d%0d expected %0d got %0d", i / 3, i % 3,
							want.m[i], got[i]);
						n_errors++;
					end
				if (axis_invalid !== want.invalid) begin
					$error("axis_invalid expected %0b got %0b", want.invalid, axis_invalid);
					n_errors++;
				end
			end
		end
	end

	// Extremes of every field, zero axis, folded half angles and saturating cases.
	task automatic test_directed();
		send_rotation(16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_rotation(16'sh7FFF, 16'sd0, 16'sd0, 16'sd0);
		send_rotation(-16'sd32768, 16'sd16384, 16'sd0, 16'sd0);
		send_rotation(16'sh7FFF, 16'sd0, 16'sd16384, 16'sd0);
		send_rotation(-16'sd32768, 16'sd0, 16'sd0, 16'sd16384);
		send_rotation(16'sd6434, 16'sd16384, 16'sd16384, 16'sd16384);
		send_rotation(-16'sd6434, -16'sd16384, 16'sd16384, -16'sd16384);
		send_rotation(16'sd12868, 16'sd1, 16'sd0, 16'sd0);
		send_rotation(16'sd12869, 16'sd0, 16'sd1, 16'sd0);
		send_rotation(-16'sd12869, 16'sd0, 16'sd0, -16'sd1);
		send_rotation(16'sd25736, -16'sd32768, -16'sd32768, -16'sd32768);
		send_rotation(16'sd3217, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_rotation(-16'sd1, -16'sd32768, 16'sh7FFF, 16'sd1);
		send_rotation(16'sd1, 16'sd1, 16'sd1, 16'sd1);
		send_rotation(16'sd10000, 16'sd0, 16'sd0, 16'sd0);
		send_rotation(16'sd0, -16'sd1, -16'sd1, -16'sd1);
		send_rotation(16'sd20000, 16'sh5555, -16'sh2AAA, 16'sd3);
		go_quiet();
	endtask

	// Random angles and axes; some axes are short or zero, some single-component.
	task automatic test_random(int count, int pct);
		logic signed [IN_W-1:0] a, v [3];
		idle_pct = pct;
		repeat (count) begin
			a = IN_W'($urandom);
			foreach (v[i])
				case ($urandom_range(9))
					0: v[i] = '0;
					1: v[i] = IN_W'(int'($urandom_range(3)) - 2);
					2: v[i] = ($urandom_range(1) == 1) ? 16'sh7FFF : -16'sd32768;
					default: v[i] = IN_W'($urandom);
				endcase
			if ($urandom_range(49) == 0)
				v = '{16'sd0, 16'sd0, 16'sd0};
			send_rotation(a, v[0], v[1], v[2]);
		end
		go_quiet();
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		start = 1'b0;
		angle = '0;
		axis_x = '0;
		axis_y = '0;
		axis_z = '0;
		idle_pct = 0;
		n_sent = 0;
		n_checked = 0;
		n_invalid_axes = 0;
		n_errors = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(450, 0);
		test_random(450, 73);
		test_random(400, 0);
		test_random(450, 27);

		waited = 0;
		while (expected_matrices.size() != 0 && waited < 100 * LATENCY) begin
			@(negedge clk);
			waited++;
		end
		repeat (2 * LATENCY) @(negedge clk);
		if (expected_matrices.size() != 0) begin
			$error("%0d predicted matrices never came out", expected_matrices.size());
			n_errors++;
		end

		$display("Sent %0d rotations (%0d with a zero axis), checked %0d matrices.",
			n_sent, n_invalid_axes, n_checked);
		$display("Phases: back-to-back, sender idle 73%%, back-to-back, sender idle 27%%.");
		if (n_errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* files.f */
rtl/aar_pkg.sv
rtl/aar_front.sv
rtl/aar_fifo.sv
rtl/aar_back.sv
rtl/axis_angle_rotation_matrix.sv
tb/axis_angle_rotation_matrix_tb.sv
